@@ rtl/fsv_pkg.sv @@
// ----------------------------------------------------------------------------
// fsv_pkg
// Types and constants shared by the FASTA stream validator.
// ----------------------------------------------------------------------------
package fsv_pkg;

  localparam logic [7:0] NewlineByte    = 8'h0A;
  localparam logic [7:0] HeaderMark     = 8'h3E;
  localparam logic [7:0] BaseA          = 8'h41;
  localparam logic [7:0] BaseC          = 8'h43;
  localparam logic [7:0] BaseG          = 8'h47;
  localparam logic [7:0] BaseT          = 8'h54;
  localparam logic [7:0] BaseN          = 8'h4E;
  localparam logic [7:0] LowerA         = 8'h61;
  localparam logic [7:0] LowerZ         = 8'h7A;
  localparam logic [7:0] CaseOffset     = 8'h20;
  localparam logic [7:0] MaxLineReset   = 8'd80;

  localparam int unsigned PaddrWidth    = 3;
  localparam int unsigned PdataWidth    = 32;
  localparam logic [0:0]  RegMaxLine    = 1'b0;

  localparam logic ReqText = 1'b0;
  localparam logic ReqEnd  = 1'b1;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_SEQ    = 2'd2
  } line_mode_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_NAME   = 3'd1,
    KIND_BASE   = 3'd2,
    KIND_CLOSED = 3'd3,
    KIND_ACCEPT = 3'd4,
    KIND_REJECT = 3'd5
  } out_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_EMPTY_LINE  = 3'd1,
    ERR_BARE_HEADER = 3'd2,
    ERR_EMPTY_REC   = 3'd3,
    ERR_NO_HEADER   = 3'd4,
    ERR_LONG_LINE   = 3'd5,
    ERR_BAD_CHAR    = 3'd6,
    ERR_LAST_EMPTY  = 3'd7
  } error_code_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_kind;
    logic [7:0] out_char;
    logic [2:0] error_code;
  } out_item_t;

endpackage

@@ rtl/fasta_stream_validator.sv @@
// ----------------------------------------------------------------------------
// fasta_stream_validator
// Checks a FASTA byte stream, emits name bytes, upper-case bases and record-close
// marks, and reports accept or the first error at end of stream.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o    fsv_pkg::in_item_t
//  out       output     out_valid_o / out_ready_i  fsv_pkg::out_item_t
//  cfg       input      APB psel/penable/pready    max_line_length at 0x0
//
//  The parse state loads at the input transfer edge; the result loads into the
//  output register, or into the skid register while a result waits there.
//  A skid register behind the output register keeps the input open for one
//  more transfer while a result waits; ready drops only when both are full.
//  Reset clears the parse state and sets max_line_length to 80.
//  Every input transfer yields exactly one output transfer.
module fasta_stream_validator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fsv_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fsv_pkg::out_item_t                  out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fsv_pkg::PaddrWidth-1:0]      paddr,
  input  logic [fsv_pkg::PdataWidth-1:0]      pwdata,
  output logic [fsv_pkg::PdataWidth-1:0]      prdata,
  output logic                                pready
);
  import fsv_pkg::*;

  logic [7:0]  max_line_q;
  line_mode_e  mode_q, mode_d;
  logic [7:0]  count_q, count_d;
  logic        rec_open_q, rec_open_d;
  logic        has_base_q, has_base_d;
  logic        named_q, named_d;
  logic [2:0]  err_q, err_d;

  out_item_t   res;
  out_item_t   out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_fire, out_fire;
  logic [7:0]  up_byte;
  logic        is_base;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[PaddrWidth-1] == RegMaxLine) ?
                  {{(PdataWidth-8){1'b0}}, max_line_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= MaxLineReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PaddrWidth-1] == RegMaxLine) begin
      max_line_q <= pwdata[7:0];
    end
  end

  always_comb begin
    up_byte = in_data_i.in_byte;
    if (in_data_i.in_byte >= LowerA && in_data_i.in_byte <= LowerZ) begin
      up_byte = in_data_i.in_byte - CaseOffset;
    end
    is_base = (up_byte == BaseA) || (up_byte == BaseC) || (up_byte == BaseG) ||
              (up_byte == BaseT) || (up_byte == BaseN);
  end

  // Parse step: next state and result for the item at the input
  always_comb begin
    mode_d     = mode_q;
    count_d    = count_q;
    rec_open_d = rec_open_q;
    has_base_d = has_base_q;
    named_d    = named_q;
    err_d      = err_q;
    res        = '{out_kind: KIND_NONE, out_char: 8'h00, error_code: ERR_NONE};

    if (in_data_i.req_type == ReqEnd) begin
      if (err_q == ERR_NONE && mode_q == MODE_HEADER && !named_q) begin
        err_d = ERR_BARE_HEADER;
      end else if (err_q == ERR_NONE && !has_base_q) begin
        err_d = ERR_LAST_EMPTY;
      end
      if (err_d != ERR_NONE) begin
        res.out_kind   = KIND_REJECT;
        res.error_code = err_d;
      end else begin
        res.out_kind = KIND_ACCEPT;
      end
      mode_d     = MODE_START;
      count_d    = '0;
      rec_open_d = 1'b0;
      has_base_d = 1'b0;
      named_d    = 1'b0;
      err_d      = ERR_NONE;
    end else if (err_q != ERR_NONE) begin
      // stay silent until end of stream
    end else if (in_data_i.in_byte == NewlineByte) begin
      unique case (mode_q)
        MODE_START: err_d = ERR_EMPTY_LINE;
        MODE_HEADER: begin
          if (!named_q) err_d = ERR_BARE_HEADER;
          else          mode_d = MODE_START;
        end
        default: begin
          mode_d  = MODE_START;
          count_d = '0;
        end
      endcase
    end else if (mode_q == MODE_HEADER) begin
      res.out_kind = KIND_NAME;
      res.out_char = in_data_i.in_byte;
      named_d      = 1'b1;
    end else if (mode_q == MODE_START && in_data_i.in_byte == HeaderMark) begin
      if (rec_open_q && !has_base_q) begin
        err_d = ERR_EMPTY_REC;
      end else begin
        if (rec_open_q) res.out_kind = KIND_CLOSED;
        rec_open_d = 1'b1;
        has_base_d = 1'b0;
        named_d    = 1'b0;
        mode_d     = MODE_HEADER;
      end
    end else if (mode_q == MODE_START && !rec_open_q) begin
      err_d = ERR_NO_HEADER;
    end else begin
      // line start opens a sequence line with an empty count
      if (mode_q == MODE_START) begin
        mode_d = MODE_SEQ;
      end
      if (!is_base) begin
        err_d = ERR_BAD_CHAR;
      end else if (mode_q != MODE_START && count_q >= max_line_q) begin
        err_d = ERR_LONG_LINE;
      end else if (mode_q == MODE_START && max_line_q == 8'd0) begin
        err_d = ERR_LONG_LINE;
      end else begin
        count_d      = (mode_q == MODE_START) ? 8'd1 : count_q + 8'd1;
        has_base_d   = 1'b1;
        res.out_kind = KIND_BASE;
        res.out_char = up_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_START;
      count_q    <= '0;
      rec_open_q <= 1'b0;
      has_base_q <= 1'b0;
      named_q    <= 1'b0;
      err_q      <= ERR_NONE;
    end else if (in_fire) begin
      mode_q     <= mode_d;
      count_q    <= count_d;
      rec_open_q <= rec_open_d;
      has_base_q <= has_base_d;
      named_q    <= named_d;
      err_q      <= err_d;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_fire) begin
        out_valid_q  <= skid_valid_q || in_fire;
        skid_valid_q <= skid_valid_q && in_fire;
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (in_fire) skid_q <= res;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the output register is empty");

  a_err_only_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.error_code != ERR_NONE) == (out_q.out_kind == KIND_REJECT)))
    else $error("error code and result kind disagree");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.req_type == ReqEnd) |=>
      (mode_q == MODE_START && err_q == ERR_NONE && !rec_open_q && !has_base_q))
    else $error("end of stream left parse state behind");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE && !(in_fire && in_data_i.req_type == ReqEnd)) |=>
      (err_q == $past(err_q)))
    else $error("latched error changed before end of stream");

  a_count_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != 8'd0) |-> (mode_q == MODE_SEQ))
    else $error("base count nonzero outside a sequence line");
`endif

endmodule
